@@ design/assert_macros.svh @@
// Assertion macros used by the responder's emitter module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define DQR_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle that implies a consequence in the next cycle.
`define DQR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/dqr_pkg.sv @@
// Types, constants and the answer-record table of the DNS query responder.
`default_nettype none

package dqr_pkg;

   // Rewritten header flags: QR, AA and RA set.
   localparam logic [7:0] REPLY_FLAGS_HI = 8'h84;
   localparam logic [7:0] REPLY_FLAGS_LO = 8'h80;

   // Answer record constants.
   localparam logic [7:0] NAME_PTR   = 8'hc0;
   localparam logic [7:0] NAME_OFS   = 8'd12;
   localparam logic [7:0] ANSWER_TTL = 8'd60;
   localparam logic [7:0] ADDR_LEN   = 8'd4;

   // Parse limits.
   localparam logic [7:0] MAX_LABEL = 8'd63;
   localparam logic [8:0] MAX_NAME  = 9'd255;
   localparam logic [2:0] TAIL_BYTES = 3'd4;

   // Answer record is 16 bytes; the index of its final byte.
   localparam int unsigned ANS_IDX_W = 4;
   localparam logic [ANS_IDX_W-1:0] ANS_LAST_IDX = 4'd15;

   // Outcome of parsing one accepted byte.
   typedef struct packed {
      logic       emit;      // the byte has an echo
      logic [7:0] data;      // echo value
      logic       last_in;   // the byte ends the message
      logic       abort;     // at the end, the message is malformed or cut short
   } parse_result_type;

   // One byte of the A-record answer.
   function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                              input logic [31:0] addr);
      logic [7:0] val;
      case (idx)
         4'd0:    val = NAME_PTR;
         4'd1:    val = NAME_OFS;
         4'd3:    val = 8'd1;
         4'd5:    val = 8'd1;
         4'd9:    val = ANSWER_TTL;
         4'd11:   val = ADDR_LEN;
         4'd12:   val = addr[31:24];
         4'd13:   val = addr[23:16];
         4'd14:   val = addr[15:8];
         4'd15:   val = addr[7:0];
         default: val = 8'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

@@ design/dqr_parser.sv @@
// Query parser: tracks header, QNAME labels and type/class bytes, and makes the echo.
`default_nettype none

module dqr_parser #(
   parameter int unsigned MAX_MESSAGE_BYTES = 300
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic [7:0]                data_byte,
   input  wire logic                      end_of_message,
   output dqr_pkg::parse_result_type      result
);

   localparam int unsigned POS_W = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_MESSAGE_BYTES);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_LABLEN,
      PH_LABEL,
      PH_TAIL,
      PH_DONE
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [5:0]       label_ff, label_in;
   logic [8:0]       name_ff, name_in;
   logic [2:0]       tail_ff, tail_in;
   logic [7:0]       qc_high_ff, qc_high_in;
   logic             invalid_ff, invalid_in;
   logic             emit;
   logic [7:0]       echo;
   logic             active;

   // Next parse state and echo for the byte on the input.
   always_comb begin
      phase_in   = phase_ff;
      label_in   = label_ff;
      name_in    = name_ff;
      tail_in    = tail_ff;
      qc_high_in = qc_high_ff;
      invalid_in = invalid_ff;
      emit       = 1'b0;
      echo       = 8'd0;
      active     = (pos_ff < POS_LIMIT) && !invalid_ff;

      if (active) begin
         case (phase_ff)
            PH_HEADER: begin
               emit = 1'b1;
               if (pos_ff == POS_W'(0) || pos_ff == POS_W'(1)) begin
                  echo = data_byte;
               end else if (pos_ff == POS_W'(2)) begin
                  echo = dqr_pkg::REPLY_FLAGS_HI;
                  // QR set or a nonzero opcode.
                  if (data_byte[7] || data_byte[6:3] != 4'd0) begin
                     invalid_in = 1'b1;
                  end
               end else if (pos_ff == POS_W'(3)) begin
                  echo = dqr_pkg::REPLY_FLAGS_LO;
               end else if (pos_ff == POS_W'(4)) begin
                  qc_high_in = data_byte;
               end else if (pos_ff == POS_W'(5)) begin
                  echo = 8'd1;
                  // No question at all.
                  if (qc_high_ff == 8'd0 && data_byte == 8'd0) begin
                     invalid_in = 1'b1;
                  end
               end else if (pos_ff == POS_W'(7)) begin
                  echo = 8'd1;
               end
               if (pos_ff >= POS_W'(11)) begin
                  phase_in = PH_LABLEN;
               end
            end
            PH_LABLEN: begin
               emit    = 1'b1;
               echo    = data_byte;
               name_in = (name_ff <= dqr_pkg::MAX_NAME) ? name_ff + 9'd1 : name_ff;
               if (name_in > dqr_pkg::MAX_NAME) begin
                  invalid_in = 1'b1;
               end
               if (data_byte == 8'd0) begin
                  phase_in = PH_TAIL;
                  tail_in  = dqr_pkg::TAIL_BYTES;
               end else if (data_byte > dqr_pkg::MAX_LABEL) begin
                  invalid_in = 1'b1;
               end else begin
                  label_in = data_byte[5:0];
                  phase_in = PH_LABEL;
               end
            end
            PH_LABEL: begin
               emit    = 1'b1;
               echo    = data_byte;
               name_in = (name_ff <= dqr_pkg::MAX_NAME) ? name_ff + 9'd1 : name_ff;
               if (name_in > dqr_pkg::MAX_NAME) begin
                  invalid_in = 1'b1;
               end
               if (label_ff != 6'd0) begin
                  label_in = label_ff - 6'd1;
               end
               if (label_ff <= 6'd1) begin
                  phase_in = PH_LABLEN;
               end
            end
            PH_TAIL: begin
               emit = 1'b1;
               echo = data_byte;
               if (tail_ff != 3'd0) begin
                  tail_in = tail_ff - 3'd1;
               end
               if (tail_ff <= 3'd1) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
            end
         endcase
      end

      if (invalid_in) begin
         emit = 1'b0;
      end

      pos_in = (pos_ff < POS_LIMIT) ? pos_ff + POS_W'(1) : pos_ff;
   end

   // Outcome of this byte: echo flag, echo value, end of message and abort.
   assign result = {emit, echo, end_of_message, invalid_in || (phase_in != PH_DONE)};

   // Parse state; cleared after every message.
   always_ff @(posedge clock) begin
      if (reset || (accept && end_of_message)) begin
         phase_ff   <= PH_HEADER;
         pos_ff     <= '0;
         label_ff   <= '0;
         name_ff    <= '0;
         tail_ff    <= '0;
         qc_high_ff <= '0;
         invalid_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         pos_ff     <= pos_in;
         label_ff   <= label_in;
         name_ff    <= name_in;
         tail_ff    <= tail_in;
         qc_high_ff <= qc_high_in;
         invalid_ff <= invalid_in;
      end
   end

endmodule

`default_nettype wire

@@ design/dqr_emitter.sv @@
// Result register and answer-record sequencer.
`default_nettype none
`include "assert_macros.svh"

module dqr_emitter (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire dqr_pkg::parse_result_type parsed,
   input  wire logic [31:0]               server_address,
   output logic                           in_ready,
   output logic                           out_valid,
   input  wire logic                      out_ready,
   output logic [7:0]                     out_byte,
   output logic                           out_last,
   output logic                           out_drop
);

   logic                           valid_ff, valid_in;
   logic [7:0]                     byte_ff, byte_in;
   logic                           last_ff, last_in;
   logic                           drop_ff, drop_in;
   logic                           busy_ff, busy_in;
   logic [dqr_pkg::ANS_IDX_W-1:0]  idx_ff, idx_in;
   logic                           slot_free;
   logic                           ans_stall;
   logic                           ans_final;
   logic                           answer_out;
   logic                           abort_take;
   logic                           marker_out;

   // The result register can take a new value when empty or being drained.
   assign slot_free = !valid_ff || out_ready;
   assign in_ready  = slot_free && !busy_ff;

   // Select what goes into the result register next.
   always_comb begin
      valid_in = valid_ff && !out_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      drop_in  = drop_ff;
      busy_in  = busy_ff;
      idx_in   = idx_ff;

      if (busy_ff && slot_free) begin
         // Answer record, one byte per transfer.
         valid_in = 1'b1;
         byte_in  = dqr_pkg::answer_byte(idx_ff, server_address);
         last_in  = (idx_ff == dqr_pkg::ANS_LAST_IDX);
         drop_in  = 1'b0;
         idx_in   = idx_ff + dqr_pkg::ANS_IDX_W'(1);
         if (idx_ff == dqr_pkg::ANS_LAST_IDX) begin
            busy_in = 1'b0;
         end
      end else if (accept) begin
         if (parsed.last_in && parsed.abort) begin
            // Abort marker replaces the final echo.
            valid_in = 1'b1;
            byte_in  = 8'd0;
            last_in  = 1'b1;
            drop_in  = 1'b1;
         end else if (parsed.emit) begin
            valid_in = 1'b1;
            byte_in  = parsed.data;
            last_in  = 1'b0;
            drop_in  = 1'b0;
            if (parsed.last_in) begin
               busy_in = 1'b1;
               idx_in  = '0;
            end
         end else if (parsed.last_in) begin
            // No echo for the final byte: the answer starts at once.
            valid_in = 1'b1;
            byte_in  = dqr_pkg::answer_byte('0, server_address);
            last_in  = 1'b0;
            drop_in  = 1'b0;
            busy_in  = 1'b1;
            idx_in   = dqr_pkg::ANS_IDX_W'(1);
         end
      end
   end

   // Result register and sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
      end
      byte_ff <= byte_in;
      last_ff <= last_in;
      drop_ff <= drop_in;
   end

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_drop  = drop_ff;

   // Conditions watched by the checks below.
   assign ans_stall  = busy_ff && !slot_free;
   assign ans_final  = busy_ff && slot_free && (idx_ff == dqr_pkg::ANS_LAST_IDX);
   assign answer_out = valid_ff && last_ff && !drop_ff && !busy_ff;
   assign abort_take = accept && parsed.last_in && parsed.abort;
   assign marker_out = valid_ff && drop_ff && last_ff && (byte_ff == 8'd0);

   // A drop flag only ever sits on a final result.
   `DQR_ASSERT(a_drop_is_last, clock, reset, !valid_ff || !drop_ff || last_ff, "drop without last")
   // The answer index holds while the result register is stalled.
   `DQR_ASSERT_NEXT(a_idx_hold, clock, reset, ans_stall, $stable(idx_ff), "index moved in stall")
   // The sixteenth answer byte closes the frame.
   `DQR_ASSERT_NEXT(a_answer_end, clock, reset, ans_final, answer_out, "answer did not end")
   // A malformed message ends in the abort marker.
   `DQR_ASSERT_NEXT(a_abort_marker, clock, reset, abort_take, marker_out, "abort marker missing")

endmodule

`default_nettype wire

@@ design/dns_query_responder.sv @@
// Top level of the DNS A-record responder.
//
//   Channel   Direction  Payload
//   req_      in         tdata = data_byte[7:0], tlast = end_of_message
//   rsp_      out        tdata = reply_byte[7:0], tlast = reply_last, tuser = reply_drop
//   csr_      in         wr_data = server_address[31:0]
//
// One query byte is taken per cycle while req_tready is high; its echo is registered
// and appears in the next cycle. After a well-formed final byte the 16 answer bytes
// follow one per cycle while rsp_tready is high; req_tready stays low meanwhile.
// A stall on rsp_tready holds the result register and stops input at once.
// Reset is synchronous; it clears the parse state, the sequencer and the address.
`default_nettype none

module dns_query_responder #(
   parameter int unsigned MAX_MESSAGE_BYTES = 300
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Query stream.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,
   // Reply stream.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] reply_byte
   output logic             rsp_tlast,
   output logic             rsp_tuser,   // [0] reply_drop
   // Address register.
   input  wire logic        csr_wr_en,
   input  wire logic [31:0] csr_wr_data
);

   logic                      accept;
   logic [31:0]               server_address_ff;
   dqr_pkg::parse_result_type parsed;

   // An item transfer on the query side.
   assign accept = req_tvalid && req_tready;

   // Server address register.
   always_ff @(posedge clock) begin
      if (reset) begin
         server_address_ff <= '0;
      end else if (csr_wr_en) begin
         server_address_ff <= csr_wr_data;
      end
   end

   dqr_parser #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_parser (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .data_byte      (req_tdata),
      .end_of_message (req_tlast),
      .result         (parsed)
   );

   dqr_emitter u_emitter (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .parsed         (parsed),
      .server_address (server_address_ff),
      .in_ready       (req_tready),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_byte       (rsp_tdata),
      .out_last       (rsp_tlast),
      .out_drop       (rsp_tuser)
   );

endmodule

`default_nettype wire
